### src/npc_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// npc_pkg: shared types and constants for the nearest palette color block
// Pixel and result request types, the built-in RGB888 palette and the node
// type and pick function of the minimum search tree.
// ----------------------------------------------------------------------------
package npc_pkg;

  // Palette table depth, also the number of tree leaves
  localparam int TABLE_DEPTH = 16;
  localparam int IDX_W       = 4;
  localparam int DIST_W      = 18;
  localparam int SQ_W        = 16;

  // Largest possible squared distance, 3 * 255 * 255
  localparam logic [DIST_W-1:0] MAX_DIST = 18'd195075;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } pixel_t;

  typedef struct packed {
    logic [IDX_W-1:0]  palette_index;
    logic [DIST_W-1:0] best_distance;
  } result_t;

  // One candidate in the minimum search
  typedef struct packed {
    logic              vld;
    logic [IDX_W-1:0]  idx;
    logic [DIST_W-1:0] dist_sq;
  } node_t;

  typedef logic [23:0] rgb_t;

  // Built-in palette; entries past the twelfth are black
  localparam rgb_t PALETTE [TABLE_DEPTH] = '{
    24'h141428, 24'hFFFFFF, 24'hFF4444, 24'h44FF44,
    24'h4444FF, 24'hFFFF44, 24'hFF44FF, 24'h44FFFF,
    24'h884400, 24'h888888, 24'h000000, 24'hFF8800,
    24'h000000, 24'h000000, 24'h000000, 24'h000000
  };

  // Pick the better of two candidates; lo holds the lower indexes, so it
  // wins a tie
  function automatic node_t node_pick(input node_t lo, input node_t hi);
    node_t res;
    if (hi.vld && (!lo.vld || (hi.dist_sq < lo.dist_sq))) begin
      res = hi;
    end else begin
      res = lo;
    end
    return res;
  endfunction

endpackage
`default_nettype wire

### src/nearest_palette_color.sv
`default_nettype none
// ----------------------------------------------------------------------------
// nearest_palette_color: maps an RGB888 pixel to its nearest palette entry
// Four-stage pipeline: squared component differences, per-entry sums, and two
// registered levels each of a pairwise minimum tree over the palette.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel in_valid / in_stall / in_data carries one pixel per request.
//   Result channel out_valid / out_stall / out_data carries the index of the
//   nearest palette entry (squared Euclidean distance, lowest index on a tie)
//   and that distance. A request moves when valid is high and stall is low.
//   The result is registered through stage registers 1 to 4 in turn. Throughput
//   is one pixel per cycle while out_stall is low, set by the four pipeline
//   registers that each take a new pixel every cycle when not stalled; there is
//   no loop or shared unit.
//   Each stage holds its contents while the stage after it is full and not
//   moving, so a stall on out_stall backs up stage by stage; in_stall rises
//   only once every stage is full. Bubbles are squeezed out meanwhile.
//   Reset clears all stage valid bits; no pixel is in flight afterwards and
//   the block takes a pixel in the first cycle after reset.
//   PALETTE_SIZE (2..16) sets how many palette entries are searched.
// ----------------------------------------------------------------------------
module nearest_palette_color #(
  parameter int PALETTE_SIZE = 12
) (
  input  wire                    clk,
  input  wire                    rst_n,
  input  wire                    in_valid,
  output logic                   in_stall,
  input  wire npc_pkg::pixel_t   in_data,
  output logic                   out_valid,
  input  wire                    out_stall,
  output npc_pkg::result_t       out_data
);
  import npc_pkg::*;

  localparam int L1_N = TABLE_DEPTH / 2;
  localparam int L2_N = TABLE_DEPTH / 4;
  localparam int L3_N = TABLE_DEPTH / 8;

  // Stage valid bits and payload registers
  logic s1_vld_r, s2_vld_r, s3_vld_r, s4_vld_r;
  logic s1_vld_nxt, s2_vld_nxt, s3_vld_nxt, s4_vld_nxt;
  logic en1, en2, en3, en4;

  logic [SQ_W-1:0]   s1_sq_r   [TABLE_DEPTH][3];
  logic [SQ_W-1:0]   s1_sq_nxt [TABLE_DEPTH][3];
  logic [DIST_W-1:0] s2_dist_r   [TABLE_DEPTH];
  logic [DIST_W-1:0] s2_dist_nxt [TABLE_DEPTH];
  node_t             s3_node_r   [L2_N];
  node_t             s3_node_nxt [L2_N];
  node_t             s4_node_r;
  node_t             s4_node_nxt;

  node_t leaf [TABLE_DEPTH];
  node_t lvl1 [L1_N];
  node_t lvl3 [L3_N];

  // Stage enables: a stage moves when empty or when the next one moves
  always_comb begin
    en4 = !s4_vld_r || !out_stall;
    en3 = !s3_vld_r || en4;
    en2 = !s2_vld_r || en3;
    en1 = !s1_vld_r || en2;
  end

  assign in_stall = !en1;

  // Stage 1: absolute component differences and their squares
  always_comb begin
    logic [7:0] d_r, d_g, d_b;
    logic [7:0] p_r, p_g, p_b;
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      p_r = PALETTE[i][23:16];
      p_g = PALETTE[i][15:8];
      p_b = PALETTE[i][7:0];
      d_r = (in_data.red   > p_r) ? (in_data.red   - p_r) : (p_r - in_data.red);
      d_g = (in_data.green > p_g) ? (in_data.green - p_g) : (p_g - in_data.green);
      d_b = (in_data.blue  > p_b) ? (in_data.blue  - p_b) : (p_b - in_data.blue);
      s1_sq_nxt[i][0] = SQ_W'(d_r) * SQ_W'(d_r);
      s1_sq_nxt[i][1] = SQ_W'(d_g) * SQ_W'(d_g);
      s1_sq_nxt[i][2] = SQ_W'(d_b) * SQ_W'(d_b);
    end
  end

  // Stage 2: per-entry distance
  always_comb begin
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      s2_dist_nxt[i] = DIST_W'(s1_sq_r[i][0]) + DIST_W'(s1_sq_r[i][1])
                     + DIST_W'(s1_sq_r[i][2]);
    end
  end

  // Stage 3: leaves and the first two tree levels; unused entries are invalid
  always_comb begin
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      leaf[i].vld     = (i < PALETTE_SIZE);
      leaf[i].idx     = IDX_W'(i);
      leaf[i].dist_sq = s2_dist_r[i];
    end
    for (int i = 0; i < L1_N; i++) begin
      lvl1[i] = node_pick(leaf[2*i], leaf[2*i+1]);
    end
    for (int i = 0; i < L2_N; i++) begin
      s3_node_nxt[i] = node_pick(lvl1[2*i], lvl1[2*i+1]);
    end
  end

  // Stage 4: last two tree levels
  always_comb begin
    for (int i = 0; i < L3_N; i++) begin
      lvl3[i] = node_pick(s3_node_r[2*i], s3_node_r[2*i+1]);
    end
    s4_node_nxt = node_pick(lvl3[0], lvl3[1]);
  end

  // Valid bits move with the data
  always_comb begin
    s1_vld_nxt = en1 ? in_valid : s1_vld_r;
    s2_vld_nxt = en2 ? s1_vld_r : s2_vld_r;
    s3_vld_nxt = en3 ? s2_vld_r : s3_vld_r;
    s4_vld_nxt = en4 ? s3_vld_r : s4_vld_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
      s2_vld_r <= 1'b0;
      s3_vld_r <= 1'b0;
      s4_vld_r <= 1'b0;
    end else begin
      s1_vld_r <= s1_vld_nxt;
      s2_vld_r <= s2_vld_nxt;
      s3_vld_r <= s3_vld_nxt;
      s4_vld_r <= s4_vld_nxt;
    end
  end

  // Payload registers, no reset
  always_ff @(posedge clk) begin
    if (en1) begin
      s1_sq_r <= s1_sq_nxt;
    end
    if (en2) begin
      s2_dist_r <= s2_dist_nxt;
    end
    if (en3) begin
      s3_node_r <= s3_node_nxt;
    end
    if (en4) begin
      s4_node_r <= s4_node_nxt;
    end
  end

  // Output register is stage 4
  assign out_valid              = s4_vld_r;
  assign out_data.palette_index = s4_node_r.idx;
  assign out_data.best_distance = s4_node_r.dist_sq;

  // Checks
  a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (32'(out_data.palette_index) < PALETTE_SIZE))
    else $error("palette index beyond searched entries");

  a_dist_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.best_distance <= MAX_DIST))
    else $error("distance above largest possible value");

  a_empty_takes: assert property (@(posedge clk) disable iff (!rst_n)
    !s1_vld_r |-> !in_stall)
    else $error("input stalled with empty first stage");

  a_full_stalls: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_vld_r && s2_vld_r && s3_vld_r && s4_vld_r && out_stall) |-> in_stall)
    else $error("input taken while pipeline full and stalled");

endmodule
`default_nettype wire

### verif/nearest_palette_color_chk.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nearest_palette_color_chk: result checker for the nearest palette color block
// Watches both request channels. Every accepted pixel gets its nearest palette
// entry worked out here; every accepted result is compared with the oldest
// outstanding prediction. Mismatch count and outstanding count go to the top.
// ----------------------------------------------------------------------------
module nearest_palette_color_chk (
  input  wire                clk,
  input  wire                rst_n,
  input  wire                in_valid,
  input  wire                in_stall,
  input  npc_pkg::pixel_t    in_data,
  input  wire                out_valid,
  input  wire                out_stall,
  input  npc_pkg::result_t   out_data,
  output int                 fail_count,
  output int                 matches_waiting
);
  import npc_pkg::*;

  // Entries searched with the default palette size
  localparam int N_SWATCH = 12;

  result_t matches_due[$];
  int      mismatches = 0;

  // Built-in palette colors, RGB888
  function automatic logic [23:0] swatch(input int i);
    logic [23:0] c;
    case (i)
      0:       c = 24'h141428;
      1:       c = 24'hFFFFFF;
      2:       c = 24'hFF4444;
      3:       c = 24'h44FF44;
      4:       c = 24'h4444FF;
      5:       c = 24'hFFFF44;
      6:       c = 24'hFF44FF;
      7:       c = 24'h44FFFF;
      8:       c = 24'h884400;
      9:       c = 24'h888888;
      10:      c = 24'h000000;
      11:      c = 24'hFF8800;
      default: c = 24'h000000;
    endcase
    return c;
  endfunction

  // Nearest entry by squared distance; strict compare keeps the lower index
  function automatic result_t match_palette(input pixel_t px);
    result_t     res;
    logic [23:0] c;
    int          dr;
    int          dg;
    int          db;
    int          d;
    res = '0;
    for (int i = 0; i < N_SWATCH; i++) begin
      c  = swatch(i);
      dr = int'(px.red)   - int'(c[23:16]);
      dg = int'(px.green) - int'(c[15:8]);
      db = int'(px.blue)  - int'(c[7:0]);
      d  = dr * dr + dg * dg + db * db;
      if (i == 0 || d < int'(res.best_distance)) begin
        res.palette_index = IDX_W'(i);
        res.best_distance = DIST_W'(d);
      end
    end
    return res;
  endfunction

  always @(posedge clk) begin
    result_t want;
    if (rst_n) begin
      // Results first: nothing accepted this edge can show up this edge
      if (out_valid && !out_stall) begin
        if (matches_due.size() == 0) begin
          $error("result with no pixel outstanding: palette_index %0d best_distance %0d",
                 out_data.palette_index, out_data.best_distance);
          mismatches++;
        end else begin
          want = matches_due.pop_front();
          if (out_data.palette_index !== want.palette_index) begin
            $error("palette_index mismatch: expected %0d, actual %0d",
                   want.palette_index, out_data.palette_index);
            mismatches++;
          end
          if (out_data.best_distance !== want.best_distance) begin
            $error("best_distance mismatch: expected %0d, actual %0d",
                   want.best_distance, out_data.best_distance);
            mismatches++;
          end
        end
      end
      if (in_valid && !in_stall) begin
        matches_due.push_back(match_palette(in_data));
      end
    end
    fail_count      <= mismatches;
    matches_waiting <= matches_due.size();
  end

endmodule

### verif/nearest_palette_color_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nearest_palette_color_tb: top-level testbench for nearest_palette_color
// Sends corner pixels (extremes, every palette color, exact ties) and then
// random pixels biased toward palette colors and tie points, under phases of
// sender idling and receiver stalling plus one long output hold-off.
// ----------------------------------------------------------------------------
module nearest_palette_color_tb;
  import npc_pkg::*;

  localparam int RANDOM_PER_PHASE = 250;
  localparam int N_PHASES         = 4;
  localparam int CYCLE_LIMIT      = 200000;
  localparam int DRAIN_CYCLES     = 20;
  localparam int HOLD_CYCLES      = 300;

  logic    clk       = 1'b0;
  logic    rst_n     = 1'b0;
  logic    in_valid  = 1'b0;
  pixel_t  in_data   = '0;
  logic    in_stall;
  logic    out_valid;
  logic    out_stall = 1'b0;
  result_t out_data;

  int   idle_pct  = 0;
  int   stall_pct = 0;
  logic hold_go   = 1'b0;
  logic hold_done = 1'b0;
  int   hold_cnt  = 0;
  int   cycle_cnt = 0;
  int   fail_count;
  int   matches_waiting;

  // Per-phase idle and stall rates, in percent
  int idle_by_phase  [N_PHASES] = '{0, 81, 0, 31};
  int stall_by_phase [N_PHASES] = '{0, 0, 81, 31};

  // Extremes, exact ties and bit patterns
  pixel_t corner_px [6] = '{
    24'h000000, 24'hFFFFFF,
    24'h886644,             // tie between entries 8 and 9
    24'h0A0A14,             // tie between entries 0 and 10
    24'hAA55AA, 24'h55AA55
  };

  nearest_palette_color i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  nearest_palette_color_chk i_chk (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_data         (in_data),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_data        (out_data),
    .fail_count      (fail_count),
    .matches_waiting (matches_waiting)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Run limit
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // Receiver: one long hold-off when asked, random stalls otherwise
  always @(negedge clk) begin
    if (hold_go && !hold_done) begin
      out_stall <= 1'b1;
      hold_cnt  <= hold_cnt + 1;
      if (hold_cnt == HOLD_CYCLES - 1) begin
        hold_done <= 1'b1;
      end
    end else begin
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  // Color component moved by up to 20 either way, clamped
  function automatic logic [7:0] nudge(input logic [7:0] c);
    int v;
    v = int'(c) + int'($urandom_range(40)) - 20;
    if (v < 0) v = 0;
    if (v > 255) v = 255;
    return 8'(v);
  endfunction

  // Mix of near-palette colors, midpoints of two entries and uniform pixels
  function automatic pixel_t random_pixel();
    pixel_t px;
    rgb_t   a;
    rgb_t   b;
    int     pick;
    pick = $urandom_range(99);
    a    = PALETTE[$urandom_range(11)];
    b    = PALETTE[$urandom_range(11)];
    if (pick < 40) begin
      px.red   = nudge(a[23:16]);
      px.green = nudge(a[15:8]);
      px.blue  = nudge(a[7:0]);
    end else if (pick < 60) begin
      px.red   = 8'((int'(a[23:16]) + int'(b[23:16]) + int'($urandom_range(1))) / 2);
      px.green = 8'((int'(a[15:8])  + int'(b[15:8])  + int'($urandom_range(1))) / 2);
      px.blue  = 8'((int'(a[7:0])   + int'(b[7:0])   + int'($urandom_range(1))) / 2);
    end else begin
      px = pixel_t'($urandom);
    end
    return px;
  endfunction

  // Offer one pixel request, idling first as the phase asks
  task automatic send_pixel(input pixel_t px);
    @(negedge clk);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= px;
    do @(posedge clk); while (in_stall);
  endtask

  initial begin
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;

    // Directed pixels: every palette color exactly, then the corners
    for (int i = 0; i < 12; i++) begin
      send_pixel(PALETTE[i]);
    end
    foreach (corner_px[i]) begin
      send_pixel(corner_px[i]);
    end

    // Random pixels; the first phase also holds the output off for a while
    for (int ph = 0; ph < N_PHASES; ph++) begin
      idle_pct  = idle_by_phase[ph];
      stall_pct = stall_by_phase[ph];
      if (ph == 0) begin
        hold_go = 1'b1;
      end
      repeat (RANDOM_PER_PHASE) send_pixel(random_pixel());
    end
    @(negedge clk);
    in_valid <= 1'b0;

    // Drain, then give the pipeline time to show anything extra
    do @(negedge clk); while (matches_waiting != 0);
    repeat (DRAIN_CYCLES) @(negedge clk);

    if (fail_count == 0 && matches_waiting == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
